FILE: rtl/cdf_pkg.sv
package cdf_pkg;

	localparam int MaxPoints = 1024;
	localparam int AddrW = 10;
	localparam int CntW = 11;
	localparam int ValW = 25;
	localparam int FracBits = 24;
	localparam logic [ValW-1:0] ValOne = ValW'(1) << FracBits;
	localparam logic [ValW-1:0] ValMax = '1;

	localparam logic REQ_LOAD = 1'b0;
	localparam logic REQ_MAP = 1'b1;

	typedef struct packed {
		logic             req_type;
		logic [AddrW-1:0] entry_index;
		logic [ValW-1:0]  entry_break;
		logic [ValW-1:0]  entry_cdf;
		logic [ValW-1:0]  sample;
		logic             last_sample;
	} in_beat_t;

	typedef struct packed {
		logic [ValW-1:0] mapped_value;
		logic            negative_flag;
	} out_beat_t;

endpackage

FILE: rtl/cdf_piecewise_linear_mapper.sv
// Piecewise-linear CDF mapper.
// Input channel (in_valid/in_ready/in_data) carries two kinds of beat: a load
// beat writes one breakpoint and its CDF value into the two tables, a map
// beat looks a sample up and produces one result beat on the output channel
// (out_valid/out_ready/out_data). Load beats produce no result.
// A load beat passes through the accepting cycle and then the table write.
// A map beat first reads the entry left of the search pointer, then walks
// the breakpoint table forward one entry at a time (address, then
// registered read data), then forms the sign and the product and
// runs a 50-bit restoring divider at one quotient bit a cycle. The result
// becomes valid in the same cycle that the block returns to idle and can
// take the next beat; a map beat is finished before the next is taken.
// num_points is written on cfg_we/cfg_data; the user must write it only
// while the block is idle, which the block itself does not enforce.
// Reset clears the search pointer, the control state and sets num_points to
// 1024; table contents stay undefined until loaded.
// The result sits in an output register; the block takes the next beat
// while it waits, and a finished division holds until that register is free.
module cdf_piecewise_linear_mapper (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [cdf_pkg::CntW-1:0]   cfg_data,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  cdf_pkg::in_beat_t          in_data,
	output logic                       out_valid,
	input  logic                       out_ready,
	output cdf_pkg::out_beat_t         out_data
);

	localparam int QW = 2 * cdf_pkg::ValW;       // magnitude width
	localparam int DW = cdf_pkg::ValW + 1;

	typedef enum logic [6:0] {
		ST_IDLE  = 7'b0000001,
		ST_LOAD  = 7'b0000010,
		ST_LEFT  = 7'b0000100,
		ST_READ  = 7'b0001000,
		ST_WALK  = 7'b0010000,
		ST_PREP  = 7'b0100000,
		ST_DIV   = 7'b1000000
	} state_t;

	state_t state_q;
	logic [cdf_pkg::CntW-1:0] num_q, ptr_q;
	cdf_pkg::in_beat_t req_q;
	logic [cdf_pkg::ValW-1:0] z1_q, c1_q;
	logic [cdf_pkg::ValW-1:0] brd, crd;
	logic [cdf_pkg::AddrW-1:0] raddr;
	logic [cdf_pkg::CntW-1:0] n_use;
	logic signed [DW:0] dd_q;
	logic signed [DW:0] dc_q;
	logic signed [DW:0] ds_q;
	logic [QW-1:0] mag_q, quo_q;
	logic [DW-1:0] den_q;
	logic [DW-1:0] rem_q;
	logic neg_q;
	logic [5:0] cnt_q;
	logic mul_q;
	logic we;
	logic res_fire;

	assign n_use = (num_q > cdf_pkg::CntW'(cdf_pkg::MaxPoints)) ?
		cdf_pkg::CntW'(cdf_pkg::MaxPoints) : num_q;
	assign we = (state_q == ST_LOAD);
	// The left neighbour is fetched first, then the walk reads at the pointer.
	assign raddr = (state_q == ST_LEFT) ? cdf_pkg::AddrW'(ptr_q - 1'b1) :
		ptr_q[cdf_pkg::AddrW-1:0];

	cdf_ram #(.Width(cdf_pkg::ValW), .Depth(cdf_pkg::MaxPoints)) u_brk (
		.clk, .we, .waddr(req_q.entry_index), .wdata(req_q.entry_break),
		.raddr, .rdata(brd));
	cdf_ram #(.Width(cdf_pkg::ValW), .Depth(cdf_pkg::MaxPoints)) u_cdf (
		.clk, .we, .waddr(req_q.entry_index), .wdata(req_q.entry_cdf),
		.raddr, .rdata(crd));

	assign in_ready = (state_q == ST_IDLE);

	// Magnitudes of the three differences.
	logic [DW-1:0] ad, ac, as_mag;
	assign ad = dd_q[DW] ? DW'(-dd_q) : DW'(dd_q);
	assign ac = dc_q[DW] ? DW'(-dc_q) : DW'(dc_q);
	assign as_mag = ds_q[DW] ? DW'(-ds_q) : DW'(ds_q);

	// Restoring divider step.
	logic [DW:0] rem_sh;
	logic [DW:0] rem_sub;
	assign rem_sh = {rem_q, mag_q[QW-1]};
	assign rem_sub = rem_sh - {1'b0, den_q};

	// Final signed result.
	logic signed [QW+1:0] r_full;
	assign r_full = $signed({2'b00, c1_q}) +
		(neg_q ? -$signed({2'b00, quo_q}) : $signed({2'b00, quo_q}));

	// The result register is loaded once the divider is done and the register is free.
	assign res_fire = (state_q == ST_DIV) && (cnt_q == '0) && (!out_valid || out_ready);

	// Control and datapath.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			num_q <= cdf_pkg::CntW'(cdf_pkg::MaxPoints);
			ptr_q <= '0;
			out_valid <= 1'b0;
			mul_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				num_q <= cfg_data;
			end
			if (res_fire) begin
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						req_q <= in_data;
						if (in_data.req_type == cdf_pkg::REQ_LOAD) begin
							state_q <= ST_LOAD;
						end else begin
							if (ptr_q > n_use) ptr_q <= n_use;
							state_q <= ST_LEFT;
						end
					end
				end
				ST_LOAD: begin
					state_q <= ST_IDLE;
				end
				ST_LEFT: begin
					// Entry left of the pointer is addressed.
					state_q <= ST_READ;
				end
				ST_READ: begin
					// Read data holds the entry left of the pointer; the pointer
					// entry is addressed and arrives next cycle.
					state_q <= ST_WALK;
					if (ptr_q == '0) begin
						z1_q <= '0;
						c1_q <= '0;
					end else begin
						z1_q <= brd;
						c1_q <= crd;
					end
				end
				ST_WALK: begin
					if (ptr_q < n_use && req_q.sample >= brd) begin
						ptr_q <= ptr_q + 1'b1;
						state_q <= ST_READ;
					end else begin
						if (ptr_q >= n_use) begin
							dd_q <= $signed({2'b0, cdf_pkg::ValOne}) - $signed({2'b0, z1_q});
							dc_q <= $signed({2'b0, cdf_pkg::ValOne}) - $signed({2'b0, c1_q});
						end else begin
							dd_q <= $signed({2'b0, brd}) - $signed({2'b0, z1_q});
							dc_q <= $signed({2'b0, crd}) - $signed({2'b0, c1_q});
						end
						ds_q <= $signed({2'b0, req_q.sample}) - $signed({2'b0, z1_q});
						state_q <= ST_PREP;
					end
				end
				ST_PREP: begin
					// Sign and product, then divider start.
					if (!mul_q) begin
						mag_q <= QW'(as_mag * ac);
						den_q <= (ad == '0) ? DW'(1) : ad;
						neg_q <= (dd_q[DW] ^ dc_q[DW] ^ ds_q[DW]);
						mul_q <= 1'b1;
					end else begin
						mul_q <= 1'b0;
						rem_q <= '0;
						quo_q <= '0;
						cnt_q <= 6'(QW);
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (cnt_q != '0) begin
						mag_q <= {mag_q[QW-2:0], 1'b0};
						if (!rem_sub[DW]) begin
							rem_q <= rem_sub[DW-1:0];
							quo_q <= {quo_q[QW-2:0], 1'b1};
						end else begin
							rem_q <= rem_sh[DW-1:0];
							quo_q <= {quo_q[QW-2:0], 1'b0};
						end
						cnt_q <= cnt_q - 1'b1;
					end else if (res_fire) begin
						if (r_full < 0) begin
							out_data.mapped_value <= '0;
							out_data.negative_flag <= 1'b1;
						end else begin
							out_data.mapped_value <=
								(r_full > $signed((QW+2)'(cdf_pkg::ValMax)))
								? cdf_pkg::ValMax : r_full[cdf_pkg::ValW-1:0];
							out_data.negative_flag <= 1'b0;
						end
						if (req_q.last_sample) ptr_q <= '0;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

`ifndef ASSERT_OFF
	// The pointer never runs past the count in use during a walk.
	a_ptr: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WALK) |-> (ptr_q <= n_use))
		else $error("search pointer beyond count");
	// Tables are written only in the load state.
	a_load: assert property (@(posedge clk) disable iff (!arst_n)
		we |-> $past(in_valid && in_ready))
		else $error("table write without load beat");
	// A result appears only out of the divider.
	a_res: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(state_q == ST_DIV))
		else $error("result without divide");
`endif

endmodule

FILE: rtl/cdf_ram.sv
module cdf_ram #(
	parameter int Width = 8,
	parameter int Depth = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] waddr,
	input  logic [Width-1:0]         wdata,
	input  logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0]         rdata
);

	logic [Width-1:0] mem [Depth];

	// One write port and one registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
